FILE: rtl/scaled_decimal_divide_top_defines.svh
// assertion macros for the scaled decimal divider checker
// no dependencies; included by the checker file
`ifndef SCALED_DECIMAL_DIVIDE_TOP_DEFINES_SVH
`define SCALED_DECIMAL_DIVIDE_TOP_DEFINES_SVH

// generic clocked assertion with an explicit clock and active-low reset
`define SDD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assertion on the block clock and reset
`define SDD_ASSERT(lbl, prop, msg) \
  `SDD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/sdd_pkg.sv
// shared types and constants for the scaled decimal divider
// no dependencies
`timescale 1ns / 1ps

package sdd_pkg;

  localparam int unsigned LoW     = 64;
  localparam int unsigned HiW     = 63;
  localparam int unsigned OpW     = LoW + HiW;      // operand width
  localparam int unsigned AddW    = OpW + 4;        // holds x * 10 and signed differences
  localparam int unsigned PlacesW = 6;
  localparam int unsigned CntW    = $clog2(OpW);
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    SDD_OK       = 2'd0,
    SDD_OVERFLOW = 2'd1,
    SDD_DIV_ZERO = 2'd2
  } sdd_status_e;

  typedef enum logic [2:0] {
    SDD_IDLE,
    SDD_SCALE,
    SDD_DIV,
    SDD_RCMP,
    SDD_RINC,
    SDD_DONE
  } sdd_state_e;

endpackage

FILE: rtl/sdd_req_if.sv
// request channel of the scaled decimal divider
// depends on sdd_pkg
`timescale 1ns / 1ps

interface sdd_req_if import sdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LoW-1:0]     dividend_lo;
  logic [HiW-1:0]     dividend_hi;
  logic [LoW-1:0]     divisor_lo;
  logic [HiW-1:0]     divisor_hi;
  logic [PlacesW-1:0] decimal_places;

  modport source (
    output valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi, decimal_places,
    input  ready
  );
  modport sink (
    input  valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi, decimal_places,
    output ready
  );
endinterface

FILE: rtl/sdd_rsp_if.sv
// result channel of the scaled decimal divider
// depends on sdd_pkg
`timescale 1ns / 1ps

interface sdd_rsp_if import sdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LoW-1:0]     quotient_lo;
  logic [HiW-1:0]     quotient_hi;
  logic [StatusW-1:0] status;

  modport source (
    output valid, quotient_lo, quotient_hi, status,
    input  ready
  );
  modport sink (
    input  valid, quotient_lo, quotient_hi, status,
    output ready
  );
endinterface

FILE: rtl/scaled_decimal_divide_top.sv
// scaled decimal divider: one item runs from accept to result valid through the steps below,
// ending early on overflow or a zero divisor (p = decimal_places); one shared 131-bit adder
// sequencer: p scale steps (x*10), 127 restoring divide steps, compare, increment
// a new item is taken in the cycle after the previous one leaves the sequencer at the earliest,
// so items do not overlap in the core; the result register frees the core
// rst_ni is asynchronous active low and clears the sequencer and result valid
`timescale 1ns / 1ps

module scaled_decimal_divide_top import sdd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sdd_req_if.sink         req_i,
  sdd_rsp_if.source       rsp_o
);

  // sequencer state
  sdd_state_e state_q, state_d;

  // working registers
  logic [OpW-1:0]     x_q, x_d;         // scaled dividend, then numerator/quotient shifter
  logic [OpW-1:0]     rem_q, rem_d;     // partial remainder
  logic [OpW-1:0]     den_q, den_d;     // divisor
  logic [PlacesW-1:0] places_q, places_d;
  logic [CntW-1:0]    cnt_q, cnt_d;     // divide step counter
  logic               rnd_q, rnd_d;     // round-up decision
  sdd_status_e        status_q, status_d;

  // result register, decouples the core from the result channel
  logic               out_valid_q, out_valid_d;
  logic [OpW-1:0]     out_quot_q, out_quot_d;
  sdd_status_e        out_status_q, out_status_d;

  // shared adder
  logic [AddW-1:0]    add_a, add_b, add_sum;
  logic               add_cin;

  logic               req_fire;
  logic               out_free;
  logic               scale_ovf;
  logic               div_neg;
  logic               den_zero;
  logic               div_msb;

  assign add_sum   = add_a + add_b + AddW'(add_cin);

  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  // any bit at or above 2^127 in x*10 means overflow
  assign scale_ovf = |add_sum[AddW-1:OpW];
  // subtraction went negative: trial value is below the divisor
  assign div_neg   = add_sum[AddW-1];
  assign den_zero  = ~|den_q;
  // next numerator bit shifted into the remainder
  assign div_msb   = x_q[OpW-1];

  // handshake and result outputs
  assign req_i.ready       = (state_q == SDD_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.quotient_lo = out_quot_q[LoW-1:0];
  assign rsp_o.quotient_hi = out_quot_q[OpW-1:LoW];
  assign rsp_o.status      = out_status_q;

  // adder operand selection per sequencer step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_q)
      SDD_SCALE: begin
        // x*10 = x*8 + x*2
        add_a = AddW'({x_q, 3'b000});
        add_b = AddW'({x_q, 1'b0});
      end
      SDD_DIV: begin
        // trial subtract of divisor from shifted remainder
        add_a   = AddW'({rem_q, div_msb});
        add_b   = ~AddW'(den_q);
        add_cin = 1'b1;
      end
      SDD_RCMP: begin
        // round half up: 2*rem >= divisor
        add_a   = AddW'({rem_q, 1'b0});
        add_b   = ~AddW'(den_q);
        add_cin = 1'b1;
      end
      SDD_RINC: begin
        add_a   = AddW'(x_q);
        add_cin = rnd_q;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SDD_IDLE: begin
        if (req_fire) state_d = SDD_SCALE;
      end
      SDD_SCALE: begin
        if (places_q == '0) begin
          // overflow has already been ruled out, divisor check comes second
          state_d = den_zero ? SDD_DONE : SDD_DIV;
        end else if (scale_ovf) begin
          state_d = SDD_DONE;
        end
      end
      SDD_DIV: begin
        if (cnt_q == '0) state_d = SDD_RCMP;
      end
      SDD_RCMP: state_d = SDD_RINC;
      SDD_RINC: state_d = SDD_DONE;
      SDD_DONE: begin
        if (out_free) state_d = SDD_IDLE;
      end
      default: state_d = SDD_IDLE;
    endcase
  end

  // datapath and result register updates
  always_comb begin
    x_d          = x_q;
    rem_d        = rem_q;
    den_d        = den_q;
    places_d     = places_q;
    cnt_d        = cnt_q;
    rnd_d        = rnd_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_quot_d   = out_quot_q;
    out_status_d = out_status_q;

    // result taken downstream
    if (out_valid_q && rsp_o.ready) out_valid_d = 1'b0;

    case (state_q)
      SDD_IDLE: begin
        if (req_fire) begin
          x_d      = {req_i.dividend_hi, req_i.dividend_lo};
          den_d    = {req_i.divisor_hi, req_i.divisor_lo};
          places_d = req_i.decimal_places;
          rem_d    = '0;
          status_d = SDD_OK;
        end
      end
      SDD_SCALE: begin
        if (places_q != '0) begin
          if (scale_ovf) begin
            status_d = SDD_OVERFLOW;
          end else begin
            x_d      = add_sum[OpW-1:0];
            places_d = places_q - 1'b1;
          end
        end else begin
          if (den_zero) status_d = SDD_DIV_ZERO;
          cnt_d = CntW'(OpW - 1);
        end
      end
      SDD_DIV: begin
        // quotient bits shift in from the bottom as numerator bits leave the top
        x_d   = {x_q[OpW-2:0], ~div_neg};
        rem_d = div_neg ? {rem_q[OpW-2:0], div_msb} : add_sum[OpW-1:0];
        cnt_d = cnt_q - 1'b1;
      end
      SDD_RCMP: begin
        rnd_d = ~div_neg;
      end
      SDD_RINC: begin
        x_d = add_sum[OpW-1:0];
      end
      SDD_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_quot_d   = (status_q == SDD_OK) ? x_q : '0;
          out_status_d = status_q;
        end
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SDD_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    rem_q        <= rem_d;
    den_q        <= den_d;
    places_q     <= places_d;
    cnt_q        <= cnt_d;
    rnd_q        <= rnd_d;
    status_q     <= status_d;
    out_quot_q   <= out_quot_d;
    out_status_q <= out_status_d;
  end

endmodule

FILE: rtl/sdd_checker.sv
// port-level checker for the scaled decimal divider, bound to the top level
// depends on sdd_pkg and scaled_decimal_divide_top_defines.svh
`timescale 1ns / 1ps
`include "scaled_decimal_divide_top_defines.svh"

module sdd_checker import sdd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [LoW-1:0]     quotient_lo_i,
  input logic [HiW-1:0]     quotient_hi_i,
  input logic [StatusW-1:0] status_i
);

  // busy right after taking an item
  `SDD_ASSERT(a_busy_after_accept, req_valid_i && req_ready_i |=> !req_ready_i, "ready after accept")

  // no result can appear in the cycle after an item is taken
  `SDD_ASSERT(a_no_instant_result, req_valid_i && req_ready_i |=> !$rose(rsp_valid_i), "result too early")

  // error results carry a zero quotient
  `SDD_ASSERT(a_err_zero_quot, rsp_valid_i && (status_i != SDD_OK) |-> (quotient_lo_i == '0) && (quotient_hi_i == '0), "nonzero quotient on error")

  // a stalled result holds
  `SDD_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(quotient_lo_i) && $stable(quotient_hi_i), "stalled result changed")

endmodule

bind scaled_decimal_divide_top sdd_checker u_sdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .quotient_lo_i (rsp_o.quotient_lo),
  .quotient_hi_i (rsp_o.quotient_hi),
  .status_i      (rsp_o.status)
);
